FILE: design/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

    // Parser mode
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_STR    = 3'd1,
        MODE_ESC    = 3'd2,
        MODE_HEXA   = 3'd3,
        MODE_NEEDBS = 3'd4,
        MODE_NEEDU  = 3'd5,
        MODE_HEXB   = 3'd6,
        MODE_SKIP   = 3'd7
    } t_mode;

    // Result status codes
    typedef enum logic [3:0] {
        ST_DATA        = 4'd0,
        ST_DONE        = 4'd1,
        ST_NO_QUOTE    = 4'd2,
        ST_CTRL_CHAR   = 4'd3,
        ST_TRUNC_ESC   = 4'd4,
        ST_UNKNOWN_ESC = 4'd5,
        ST_TRUNC_HEX   = 4'd6,
        ST_BAD_HEX     = 4'd7,
        ST_HIGH_NO_U   = 4'd8,
        ST_BAD_LOW     = 4'd9,
        ST_LONE_LOW    = 4'd10,
        ST_UNTERM      = 4'd11
    } t_status;

    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned CNT_W       = 3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] HIGH_LO = 16'hD800;
    localparam logic [15:0] HIGH_HI = 16'hDBFF;
    localparam logic [15:0] LOW_LO  = 16'hDC00;
    localparam logic [15:0] LOW_HI  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // Hex digit value; bit 4 set for a non-hex byte
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = 5'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: design/json_string_unescape_utf8.sv
// JSON string literal unescaper with UTF-8 output, top level.
//
// Input channel (i_in_valid / o_in_ready): one byte of the literal per item,
// starting with the opening quote; i_kind high marks end of text.
// Output channel (o_out_valid / i_out_ready): one result per item, with
// o_data_byte, o_status and o_last (last result caused by one input item).
// An item is decoded in the cycle it is accepted; its results appear on the
// output in the next cycle, one per cycle while the receiver takes them.
// Items that cause no result (quote, backslash, hex digits) produce nothing.
// Throughput: one input item per cycle while the receiver is ready; an item
// that causes N results holds off the next item while the result buffer
// drains (N is at most 4, after a surrogate pair). The next item is taken in
// the cycle the final result of the previous one leaves.
// When the receiver stalls, the buffered results hold and the input stalls
// until the final buffered result is taken.
// Reset (synchronous, i_rst_n low) empties the result buffer and returns the
// parser to idle, awaiting an opening quote.
`default_nettype none

module json_string_unescape_utf8 (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_kind,
    input  wire logic [7:0] i_text_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_data_byte,
    output logic [3:0]      o_status,
    output logic            o_last
);
    import jsu_pkg::*;

    t_mode              r_mode, n_mode;
    logic [15:0]        r_accum, n_accum;
    logic [9:0]         r_high, n_high;
    logic [1:0]         r_dcnt, n_dcnt;
    logic               r_bad, n_bad;

    logic [MAX_RESULTS-1:0][7:0] r_data;
    t_status                     r_stat;
    logic [CNT_W-1:0]            r_num;

    logic [MAX_RESULTS-1:0][7:0] res_data;
    t_status                     res_stat;
    logic [CNT_W-1:0]            res_num;

    logic        accept;
    logic        take;
    logic [4:0]  hv;
    logic [15:0] acc_shift;
    logic        bad_shift;
    logic        group_close;
    logic [15:0] cp16;
    logic [20:0] cp21;

    assign take       = o_out_valid & i_out_ready;
    assign o_in_ready = (r_num == '0) || ((r_num == CNT_W'(1)) && i_out_ready);
    assign accept     = i_in_valid & o_in_ready;

    assign hv          = hex_value(i_text_byte);
    assign acc_shift   = {r_accum[11:0], hv[3:0]};
    assign bad_shift   = r_bad | hv[4];
    assign group_close = (r_dcnt == 2'd3);
    assign cp16        = acc_shift;
    assign cp21        = SUPP_BASE + {1'b0, r_high, acc_shift[9:0]};

    // Decode one item: next parser state and its result group
    always_comb begin
        n_mode   = r_mode;
        n_accum  = r_accum;
        n_high   = r_high;
        n_dcnt   = r_dcnt;
        n_bad    = r_bad;
        res_data = '0;
        res_stat = ST_DATA;
        res_num  = '0;

        if (i_kind) begin
            n_mode = MODE_IDLE;
            res_num = CNT_W'(1);
            unique case (r_mode)
                MODE_IDLE:                res_stat = ST_NO_QUOTE;
                MODE_STR:                 res_stat = ST_UNTERM;
                MODE_ESC:                 res_stat = ST_TRUNC_ESC;
                MODE_HEXA, MODE_HEXB:     res_stat = ST_TRUNC_HEX;
                MODE_NEEDBS, MODE_NEEDU:  res_stat = ST_HIGH_NO_U;
                default:                  res_num  = '0;
            endcase
        end else begin
            unique case (r_mode)
                MODE_IDLE: begin
                    if (i_text_byte == CH_QUOTE) begin
                        n_mode = MODE_STR;
                    end else begin
                        n_mode   = MODE_SKIP;
                        res_stat = ST_NO_QUOTE;
                        res_num  = CNT_W'(1);
                    end
                end
                MODE_STR: begin
                    priority if (i_text_byte == CH_QUOTE) begin
                        n_mode   = MODE_SKIP;
                        res_stat = ST_DONE;
                        res_num  = CNT_W'(1);
                    end else if (i_text_byte < CH_SPACE) begin
                        n_mode   = MODE_SKIP;
                        res_stat = ST_CTRL_CHAR;
                        res_num  = CNT_W'(1);
                    end else if (i_text_byte == CH_BSL) begin
                        n_mode = MODE_ESC;
                    end else begin
                        res_data[0] = i_text_byte;
                        res_num     = CNT_W'(1);
                    end
                end
                MODE_ESC: begin
                    n_mode  = MODE_STR;
                    res_num = CNT_W'(1);
                    unique case (i_text_byte)
                        CH_QUOTE: res_data[0] = CH_QUOTE;
                        CH_BSL:   res_data[0] = CH_BSL;
                        CH_SLASH: res_data[0] = CH_SLASH;
                        CH_B:     res_data[0] = 8'h08;
                        CH_F:     res_data[0] = 8'h0C;
                        CH_N:     res_data[0] = 8'h0A;
                        CH_R:     res_data[0] = 8'h0D;
                        CH_T:     res_data[0] = 8'h09;
                        CH_U: begin
                            n_mode  = MODE_HEXA;
                            n_accum = '0;
                            n_dcnt  = '0;
                            n_bad   = 1'b0;
                            res_num = '0;
                        end
                        default: begin
                            n_mode   = MODE_SKIP;
                            res_stat = ST_UNKNOWN_ESC;
                        end
                    endcase
                end
                MODE_HEXA, MODE_HEXB: begin
                    n_accum = acc_shift;
                    n_bad   = bad_shift;
                    n_dcnt  = r_dcnt + 2'd1;
                    if (group_close) begin
                        res_num = CNT_W'(1);
                        priority if (bad_shift) begin
                            n_mode   = MODE_SKIP;
                            res_stat = ST_BAD_HEX;
                        end else if (r_mode == MODE_HEXB) begin
                            if (cp16 < LOW_LO || cp16 > LOW_HI) begin
                                n_mode   = MODE_SKIP;
                                res_stat = ST_BAD_LOW;
                            end else begin
                                n_mode      = MODE_STR;
                                res_num     = CNT_W'(4);
                                res_data[0] = {5'b11110, cp21[20:18]};
                                res_data[1] = {2'b10, cp21[17:12]};
                                res_data[2] = {2'b10, cp21[11:6]};
                                res_data[3] = {2'b10, cp21[5:0]};
                            end
                        end else if (cp16 >= HIGH_LO && cp16 <= HIGH_HI) begin
                            n_high  = cp16[9:0];
                            n_mode  = MODE_NEEDBS;
                            res_num = '0;
                        end else if (cp16 >= LOW_LO && cp16 <= LOW_HI) begin
                            n_mode   = MODE_SKIP;
                            res_stat = ST_LONE_LOW;
                        end else begin
                            n_mode = MODE_STR;
                            priority if (cp16 < 16'h0080) begin
                                res_data[0] = cp16[7:0];
                            end else if (cp16 < 16'h0800) begin
                                res_num     = CNT_W'(2);
                                res_data[0] = {3'b110, cp16[10:6]};
                                res_data[1] = {2'b10, cp16[5:0]};
                            end else begin
                                res_num     = CNT_W'(3);
                                res_data[0] = {4'b1110, cp16[15:12]};
                                res_data[1] = {2'b10, cp16[11:6]};
                                res_data[2] = {2'b10, cp16[5:0]};
                            end
                        end
                    end
                end
                MODE_NEEDBS: begin
                    if (i_text_byte == CH_BSL) begin
                        n_mode = MODE_NEEDU;
                    end else begin
                        n_mode   = MODE_SKIP;
                        res_stat = ST_HIGH_NO_U;
                        res_num  = CNT_W'(1);
                    end
                end
                MODE_NEEDU: begin
                    if (i_text_byte == CH_U) begin
                        n_mode  = MODE_HEXB;
                        n_accum = '0;
                        n_dcnt  = '0;
                        n_bad   = 1'b0;
                    end else begin
                        n_mode   = MODE_SKIP;
                        res_stat = ST_HIGH_NO_U;
                        res_num  = CNT_W'(1);
                    end
                end
                default: n_mode = MODE_SKIP;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_accum <= '0;
            r_high  <= '0;
            r_dcnt  <= '0;
            r_bad   <= 1'b0;
            r_num   <= '0;
        end else begin
            if (accept) begin
                r_mode  <= n_mode;
                r_accum <= n_accum;
                r_high  <= n_high;
                r_dcnt  <= n_dcnt;
                r_bad   <= n_bad;
                r_num   <= res_num;
            end else if (take) begin
                r_num <= r_num - CNT_W'(1);
            end
        end
    end

    // Result buffer payload: load a group on accept, advance on take
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= res_data;
            r_stat <= res_stat;
        end else if (take) begin
            r_data <= {8'h00, r_data[MAX_RESULTS-1:1]};
        end
    end

    assign o_out_valid = (r_num != '0);
    assign o_data_byte = r_data[0];
    assign o_status    = r_stat;
    assign o_last      = (r_num == CNT_W'(1));

    // Status results stand alone in their group
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_DATA) |-> (o_last && o_data_byte == 8'h00))
        else $error("status result not a lone zero-data result");

    // No new item while more than the final result is buffered
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_num > CNT_W'(1)) |-> !o_in_ready)
        else $error("input ready while buffer holds several results");

    // Taking a non-final result leaves the next one on the output
    a_group_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !o_last) |=> (o_out_valid && o_status == ST_DATA))
        else $error("result group broken during drain");

    // Buffer never exceeds a surrogate pair's four bytes
    a_num_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_num <= CNT_W'(MAX_RESULTS))
        else $error("result count out of range");

endmodule

`default_nettype wire

FILE: sim/tb_json_string_unescape_utf8.sv
// Testbench for the JSON string unescaper: directed table, random literals, scoreboard.
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;

    import jsu_pkg::*;

    localparam int STUCK_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 250;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
        logic       last;
    } t_res;

    typedef struct packed {
        logic       kind;
        logic [7:0] text;
    } t_item;

    // Directed row; typed rows carry their single result written out by hand
    typedef struct packed {
        logic       kind;
        logic [7:0] text;
        logic       typed;
        logic [7:0] e_data;
        t_status    e_st;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic       i_kind = 1'b0;
    logic [7:0] i_text_byte = 8'h00;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_data_byte;
    logic [3:0] o_status;
    logic       o_last;

    // Predictor state
    t_mode       ps_mode = MODE_IDLE;
    logic [15:0] gr_accum = 16'h0000;
    logic [9:0]  ps_high = 10'h000;
    logic [1:0]  gr_count = 2'd0;
    logic        gr_bad = 1'b0;

    t_res        item_bytes_q[$];
    t_res        pending_out_q[$];
    t_item       stim_q[$];
    t_row        dir_q[$];
    logic [7:0]  lit_q[$];

    int  errors = 0;
    int  stuck = 0;
    int  rx_stall = 0;
    bit  calm_tx = 1'b0;
    bit  calm_rx = 1'b0;

    json_string_unescape_utf8 DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_text_byte (i_text_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data_byte (o_data_byte),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        errors++;
        if (errors <= 50) begin
            $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
        end
    endtask

    // ---------------- predictor ----------------

    task automatic put_res(input logic [7:0] data, input t_status st);
        t_res r;
        r.data = data;
        r.status = st;
        r.last = 1'b0;
        item_bytes_q = {item_bytes_q, r};
    endtask

    task automatic abort_literal(input t_status st);
        put_res(8'h00, st);
        ps_mode = MODE_SKIP;
    endtask

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd16;
        if (c >= "0" && c <= "9") begin
            t = c - 8'h30;
        end else if (c >= "a" && c <= "f") begin
            t = c - 8'h57;
        end else if (c >= "A" && c <= "F") begin
            t = c - 8'h37;
        end
        return t[4:0];
    endfunction

    task automatic open_group(input t_mode next);
        gr_accum = 16'h0000;
        gr_count = 2'd0;
        gr_bad = 1'b0;
        ps_mode = next;
    endtask

    task automatic hex_step(input logic [7:0] c, output logic closed, output logic [15:0] val);
        logic [4:0] d;
        d = digit_of(c);
        if (d[4]) begin
            gr_bad = 1'b1;
        end
        gr_accum = {gr_accum[11:0], d[3:0]};
        closed = (gr_count == 2'd3);
        gr_count = gr_count + 2'd1;
        val = gr_accum;
    endtask

    task automatic put_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            put_res(cp[7:0], ST_DATA);
        end else if (cp < 21'h800) begin
            put_res({3'b110, cp[10:6]}, ST_DATA);
            put_res({2'b10, cp[5:0]}, ST_DATA);
        end else if (cp < 21'h10000) begin
            put_res({4'b1110, cp[15:12]}, ST_DATA);
            put_res({2'b10, cp[11:6]}, ST_DATA);
            put_res({2'b10, cp[5:0]}, ST_DATA);
        end else begin
            put_res({5'b11110, cp[20:18]}, ST_DATA);
            put_res({2'b10, cp[17:12]}, ST_DATA);
            put_res({2'b10, cp[11:6]}, ST_DATA);
            put_res({2'b10, cp[5:0]}, ST_DATA);
        end
    endtask

    // Advance the predictor by one item; fills item_bytes_q with its results
    task automatic decode_item(input logic k, input logic [7:0] c);
        logic        closed;
        logic [15:0] v;
        logic [20:0] cp;
        item_bytes_q.delete();
        closed = 1'b0;
        v = 16'h0000;
        if (k) begin
            case (ps_mode)
                MODE_IDLE: put_res(8'h00, ST_NO_QUOTE);
                MODE_STR: put_res(8'h00, ST_UNTERM);
                MODE_ESC: put_res(8'h00, ST_TRUNC_ESC);
                MODE_HEXA, MODE_HEXB: put_res(8'h00, ST_TRUNC_HEX);
                MODE_NEEDBS, MODE_NEEDU: put_res(8'h00, ST_HIGH_NO_U);
                default: ;
            endcase
            ps_mode = MODE_IDLE;
        end else begin
            case (ps_mode)
                MODE_IDLE: begin
                    if (c == CH_QUOTE) ps_mode = MODE_STR;
                    else abort_literal(ST_NO_QUOTE);
                end
                MODE_STR: begin
                    if (c == CH_QUOTE) begin
                        put_res(8'h00, ST_DONE);
                        ps_mode = MODE_SKIP;
                    end else if (c < CH_SPACE) begin
                        abort_literal(ST_CTRL_CHAR);
                    end else if (c == CH_BSL) begin
                        ps_mode = MODE_ESC;
                    end else begin
                        put_res(c, ST_DATA);
                    end
                end
                MODE_ESC: begin
                    ps_mode = MODE_STR;
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH: put_res(c, ST_DATA);
                        CH_B: put_res(8'h08, ST_DATA);
                        CH_F: put_res(8'h0C, ST_DATA);
                        CH_N: put_res(8'h0A, ST_DATA);
                        CH_R: put_res(8'h0D, ST_DATA);
                        CH_T: put_res(8'h09, ST_DATA);
                        CH_U: open_group(MODE_HEXA);
                        default: abort_literal(ST_UNKNOWN_ESC);
                    endcase
                end
                MODE_HEXA: begin
                    hex_step(c, closed, v);
                    if (closed) begin
                        if (gr_bad) begin
                            abort_literal(ST_BAD_HEX);
                        end else if (v >= HIGH_LO && v <= HIGH_HI) begin
                            ps_high = v[9:0];
                            ps_mode = MODE_NEEDBS;
                        end else if (v >= LOW_LO && v <= LOW_HI) begin
                            abort_literal(ST_LONE_LOW);
                        end else begin
                            put_utf8({5'd0, v});
                            ps_mode = MODE_STR;
                        end
                    end
                end
                MODE_NEEDBS: begin
                    if (c == CH_BSL) ps_mode = MODE_NEEDU;
                    else abort_literal(ST_HIGH_NO_U);
                end
                MODE_NEEDU: begin
                    if (c == CH_U) open_group(MODE_HEXB);
                    else abort_literal(ST_HIGH_NO_U);
                end
                MODE_HEXB: begin
                    hex_step(c, closed, v);
                    if (closed) begin
                        if (gr_bad) begin
                            abort_literal(ST_BAD_HEX);
                        end else if (v < LOW_LO || v > LOW_HI) begin
                            abort_literal(ST_BAD_LOW);
                        end else begin
                            cp = SUPP_BASE + {1'b0, ps_high, 10'b0} + {11'd0, v[9:0]};
                            put_utf8(cp);
                            ps_mode = MODE_STR;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (item_bytes_q.size() > 0) begin
            item_bytes_q[item_bytes_q.size() - 1].last = 1'b1;
        end
    endtask

    // ---------------- stimulus ----------------

    function automatic int pick_tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_tx || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_rx_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 1;
        if (r < 90) return $urandom_range(2, 4);
        if (r < 98) return $urandom_range(5, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] esc_letter(input int idx);
        case (idx)
            0: return CH_QUOTE;
            1: return CH_BSL;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_R;
            default: return CH_T;
        endcase
    endfunction

    task automatic add_row(input logic k, input logic [7:0] b, input logic typed,
                           input logic [7:0] d, input t_status st);
        t_row row;
        row.kind = k;
        row.text = b;
        row.typed = typed;
        row.e_data = d;
        row.e_st = st;
        dir_q = {dir_q, row};
    endtask

    task automatic push_hex(input logic [15:0] v);
        logic [3:0] n;
        logic [7:0] ch;
        int i;
        for (i = 3; i >= 0; i--) begin
            n = v[i*4 +: 4];
            if (n < 4'd10) ch = 8'h30 + n;
            else if ($urandom_range(0, 1) == 1) ch = 8'h57 + n;
            else ch = 8'h37 + n;
            lit_q = {lit_q, ch};
        end
    endtask

    // Build one literal, mostly well formed, sometimes broken, then end of text
    task automatic build_literal();
        int         pieces;
        int         i;
        int         r;
        int         pos;
        logic [7:0] ch;
        logic [15:0] v;
        t_item      it;
        lit_q.delete();
        ch = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : CH_QUOTE;
        lit_q = {lit_q, ch};
        pieces = $urandom_range(0, 8);
        for (i = 0; i < pieces; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                ch = 8'($urandom_range(8'h20, 8'hFF));
                if (ch == CH_QUOTE || ch == CH_BSL) ch = 8'h41;
                lit_q = {lit_q, ch};
            end else if (r < 60) begin
                lit_q = {lit_q, CH_BSL};
                lit_q = {lit_q, esc_letter($urandom_range(0, 7))};
            end else begin
                lit_q = {lit_q, CH_BSL};
                lit_q = {lit_q, CH_U};
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    v = 16'($urandom_range(0, 16'h7F));
                end else if (r < 30) begin
                    v = 16'($urandom_range(16'h80, 16'h7FF));
                end else if (r < 50) begin
                    v = 16'($urandom_range(16'h800, 16'hFFFF));
                    // keep it out of the surrogate range
                    if (v[15:11] == 5'b11011) v[14] = 1'b0;
                end else if (r < 55) begin
                    v = 16'($urandom_range(LOW_LO, LOW_HI));
                end else begin
                    push_hex(16'($urandom_range(HIGH_LO, HIGH_HI)));
                    lit_q = {lit_q, CH_BSL};
                    lit_q = {lit_q, CH_U};
                    if ($urandom_range(0, 9) == 0) v = 16'($urandom_range(0, 16'hFFFF));
                    else v = 16'($urandom_range(LOW_LO, LOW_HI));
                end
                push_hex(v);
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            lit_q = {lit_q, CH_QUOTE};
            if ($urandom_range(0, 3) == 0) begin
                pos = $urandom_range(1, 3);
                for (i = 0; i < pos; i++) lit_q = {lit_q, 8'($urandom_range(0, 255))};
            end
        end
        // Break the literal: overwrite one byte or cut it short
        r = $urandom_range(0, 99);
        if (r < 15) begin
            pos = $urandom_range(0, lit_q.size() - 1);
            lit_q[pos] = 8'($urandom_range(0, 255));
        end else if (r < 30) begin
            pos = $urandom_range(0, lit_q.size() - 1);
            while (lit_q.size() > pos) ch = lit_q.pop_back();
        end
        foreach (lit_q[j]) begin
            it.kind = 1'b0;
            it.text = lit_q[j];
            stim_q = {stim_q, it};
        end
        it.kind = 1'b1;
        it.text = 8'($urandom_range(0, 255));
        stim_q = {stim_q, it};
    endtask

    // Present one item, hold it until accepted, record its expected results
    task automatic send(input t_item it, input logic typed, input logic [7:0] e_data,
                        input t_status e_st, input bit drain);
        int   gap;
        t_res r;
        i_in_valid <= 1'b1;
        i_kind <= it.kind;
        i_text_byte <= it.text;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        decode_item(it.kind, it.text);
        if (typed) begin
            r.data = e_data;
            r.status = e_st;
            r.last = 1'b1;
            pending_out_q = {pending_out_q, r};
        end else begin
            pending_out_q = {pending_out_q, item_bytes_q};
        end
        if ($urandom_range(0, 39) == 0) calm_tx = !calm_tx;
        gap = pick_tx_gap();
        if (drain && gap == 0) gap = 1;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            while (drain && pending_out_q.size() != 0) @(posedge i_clk);
        end
    endtask

    // ---------------- receiver, checker, watchdog ----------------

    always @(posedge i_clk) begin
        if (rx_stall > 0) begin
            i_out_ready <= 1'b0;
            rx_stall--;
        end else begin
            i_out_ready <= 1'b1;
            if (!calm_rx && $urandom_range(0, 3) == 0) rx_stall = pick_rx_stall();
        end
        if ($urandom_range(0, 199) == 0) calm_rx = !calm_rx;
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_out_q.size() == 0) begin
                    report("unexpected result, status", {4'd0, o_status}, 8'h00);
                end else begin
                    want = pending_out_q.pop_front();
                    if (o_data_byte !== want.data) report("data_byte", o_data_byte, want.data);
                    if (o_status !== want.status)
                        report("status", {4'd0, o_status}, {4'd0, want.status});
                    if (o_last !== want.last) report("last", {7'd0, o_last}, {7'd0, want.last});
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stuck = 0;
            end else begin
                stuck++;
                if (stuck >= STUCK_LIMIT) begin
                    $display("[json_string_unescape_utf8] ERROR");
                    $finish;
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        t_item it;
        int    i;
        int    mid;
        bit    drain;

        add_row(1'b1, 8'h00, 1'b1, 8'h00, ST_NO_QUOTE);   // end of text at once
        add_row(1'b0, "x", 1'b1, 8'h00, ST_NO_QUOTE);     // missing opening quote
        add_row(1'b1, 8'h00, 1'b0, 8'h00, ST_DATA);       // leave skip silently
        add_row(1'b0, CH_QUOTE, 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, 8'hFF, 1'b1, 8'hFF, ST_DATA);
        add_row(1'b0, CH_SPACE, 1'b1, CH_SPACE, ST_DATA);
        // highest code point: high surrogate DBFF, low surrogate DFFF
        add_row(1'b0, CH_BSL, 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, CH_U, 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, "D", 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, "b", 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, "f", 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, "F", 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, CH_BSL, 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, CH_U, 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, "d", 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, "F", 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, "f", 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, "f", 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, CH_QUOTE, 1'b1, 8'h00, ST_DONE);
        add_row(1'b0, "z", 1'b0, 8'h00, ST_DATA);         // dropped after the close
        add_row(1'b1, 8'hFF, 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, CH_QUOTE, 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, 8'h1F, 1'b1, 8'h00, ST_CTRL_CHAR);
        add_row(1'b1, 8'h00, 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, CH_QUOTE, 1'b0, 8'h00, ST_DATA);
        add_row(1'b1, 8'h00, 1'b1, 8'h00, ST_UNTERM);
        add_row(1'b0, CH_QUOTE, 1'b0, 8'h00, ST_DATA);
        add_row(1'b0, CH_BSL, 1'b0, 8'h00, ST_DATA);
        add_row(1'b1, 8'h00, 1'b1, 8'h00, ST_TRUNC_ESC);

        while (stim_q.size() < RANDOM_ITEMS) build_literal();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_q[j]) begin
            it.kind = dir_q[j].kind;
            it.text = dir_q[j].text;
            send(it, dir_q[j].typed, dir_q[j].e_data, dir_q[j].e_st, 1'b0);
        end

        mid = stim_q.size() / 2;
        for (i = 0; i < stim_q.size(); i++) begin
            drain = (i == mid) || ($urandom_range(0, 59) == 0);
            send(stim_q[i], 1'b0, 8'h00, ST_DATA, drain);
        end
        i_in_valid <= 1'b0;

        while (pending_out_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("[json_string_unescape_utf8] OK");
        end else begin
            $display("[json_string_unescape_utf8] ERROR");
        end
        $finish;
    end

endmodule
